// File: sv/lph_pkg.sv
// Package for the linear-probing hash table: sizes, command and status codes,
// slot mark type and sequencer states. No dependencies.
package lph_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_AW = $clog2(SLOTS);
	localparam int CNT_W   = SLOT_AW + 1;
	localparam int KEY_W   = 32;
	localparam int DIGITS  = KEY_W / 4;
	localparam int DIG_W   = $clog2(DIGITS);
	localparam int CMD_W   = 2;
	localparam int ST_W    = 2;
	localparam int SLOT_W  = 4;
	localparam bit SLOTS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_SEARCH = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_ABSENT = 2'd2;

	typedef struct packed {
		logic tomb;
		logic used;
	} mark_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_PROBE,
		S_DONE
	} seq_state_t;

endpackage

// File: sv/lph_if.sv
// Request and response channel interfaces of the hash table.
// Depends on lph_pkg.
interface lph_req_if;
	logic                    valid;
	logic                    ready;
	logic [lph_pkg::CMD_W-1:0] cmd;
	logic [lph_pkg::KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface lph_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [lph_pkg::ST_W-1:0]   status;
	logic [lph_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink   (input valid, input status, input slot, output ready);
endinterface

// File: sv/linear_probe_hash_table.sv
// Linear-probing hash table: one request beat in, one response beat out.
// A request computes its home slot (a mask if SLOTS is a power of two, else a
// digit-serial modulo), probes from it over at most SLOTS slots, then loads the
// response register once that register is free; the next request is taken back
// in the idle state. One request at a time; the key and mark RAM read port sets
// the probe rate. After reset a clearing pass wipes the marks of all slots; no
// request is taken during it. Depends on lph_pkg, lph_if, lph_ram and lph_home.
module linear_probe_hash_table (
	input  logic     clk,
	input  logic     arst_n,
	lph_req_if.sink   req,
	lph_rsp_if.source rsp
);
	import lph_pkg::*;

	seq_state_t         state_q, state_d;
	logic [SLOT_AW-1:0] clr_idx_q;
	cmd_t               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [SLOT_AW-1:0] addr_q;
	logic [CNT_W-1:0]   iss_q;
	logic               rd_valid_s1;
	logic               rd_last_s1;
	logic [SLOT_AW-1:0] rd_addr_s1;
	status_t            pend_status_q;
	logic [SLOT_W-1:0]  pend_slot_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;

	logic               home_start;
	logic               home_done;
	logic [SLOT_AW-1:0] home_slot;
	logic               key_we;
	logic               mark_we;
	logic [SLOT_AW-1:0] waddr;
	mark_t              mark_wdata;
	logic [KEY_W-1:0]   key_rdata;
	mark_t              mark_rdata;
	logic               issue;
	logic               fin;
	status_t            fin_status;
	logic [SLOT_W-1:0]  fin_slot;
	logic               load_out;

	lph_home u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (home_start),
		.key    (req.key),
		.done   (home_done),
		.home   (home_slot)
	);

	lph_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_q),
		.raddr (addr_q),
		.rdata (key_rdata)
	);

	lph_ram #(.WIDTH($bits(mark_t)), .DEPTH(SLOTS)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (waddr),
		.wdata (mark_wdata),
		.raddr (addr_q),
		.rdata (mark_rdata)
	);

	always_comb begin
		state_d    = state_q;
		home_start = 1'b0;
		key_we     = 1'b0;
		mark_we    = 1'b0;
		waddr      = rd_addr_s1;
		mark_wdata = '0;
		issue      = 1'b0;
		fin        = 1'b0;
		fin_status = ST_ABSENT;
		fin_slot   = '0;
		load_out   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mark_we = 1'b1;
				waddr   = clr_idx_q;
				if (clr_idx_q == SLOT_AW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					home_start = 1'b1;
					state_d    = S_HOME;
				end
			end
			S_HOME: begin
				if (home_done) begin
					if (cmd_q inside {CMD_INSERT, CMD_SEARCH, CMD_DELETE}) begin
						state_d = S_PROBE;
					end else begin
						fin     = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_PROBE: begin
				issue = iss_q != CNT_W'(SLOTS);
				if (rd_valid_s1) begin
					if (cmd_q == CMD_INSERT) begin
						if (!mark_rdata.used) begin
							key_we          = 1'b1;
							mark_we         = 1'b1;
							mark_wdata.used = 1'b1;
							fin             = 1'b1;
							fin_status      = ST_OK;
							fin_slot        = SLOT_W'(rd_addr_s1);
						end else if (rd_last_s1) begin
							fin        = 1'b1;
							fin_status = ST_FULL;
						end
					end else begin
						if (mark_rdata.used && key_rdata == key_q) begin
							fin        = 1'b1;
							fin_status = ST_OK;
							fin_slot   = SLOT_W'(rd_addr_s1);
							if (cmd_q == CMD_DELETE) begin
								mark_we         = 1'b1;
								mark_wdata.tomb = 1'b1;
							end
						end else if ((!mark_rdata.used && !mark_rdata.tomb) || rd_last_s1) begin
							fin = 1'b1;
						end
					end
				end
				if (fin) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			iss_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (home_done) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			rd_valid_s1 <= issue && !fin;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (home_start) begin
			cmd_q <= req.cmd;
			key_q <= req.key;
		end
		if (home_done) begin
			addr_q <= home_slot;
		end else if (issue) begin
			addr_q <= (addr_q == SLOT_AW'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
		end
		if (issue) begin
			rd_addr_s1 <= addr_q;
			rd_last_s1 <= iss_q == CNT_W'(SLOTS - 1);
		end
		if (fin) begin
			pend_status_q <= fin_status;
			pend_slot_q   <= fin_slot;
		end
		if (load_out) begin
			out_status_q <= pend_status_q;
			out_slot_q   <= pend_slot_q;
		end
	end

	assign req.ready  = state_q == S_IDLE;
	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.slot   = out_slot_q;

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready)
		else $error("request taken during clearing pass");

	a_read_only_probe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q == S_PROBE && $past(state_q) == S_PROBE)
		else $error("probe read outstanding outside probe");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fin && fin_status != ST_OK |-> fin_slot == '0 && !key_we && !mark_we)
		else $error("failed command touched a slot");

	a_key_write_insert: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> cmd_q == CMD_INSERT && mark_we && fin)
		else $error("key write outside insert");

endmodule

// File: sv/lph_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module lph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/lph_home.sv
// Home slot unit: key modulo SLOTS, a mask for a power-of-two table, else four
// key bits per cycle by compare and subtract against multiples of SLOTS.
// Depends on lph_pkg.
module lph_home (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lph_pkg::KEY_W-1:0]     key,
	output logic                          done,
	output logic [lph_pkg::SLOT_AW-1:0]   home
);
	import lph_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DIG_W-1:0]   dig_q;
	logic [KEY_W-1:0]   sh_q;
	logic [SLOT_AW-1:0] rem_q;
	logic [SLOT_AW+3:0] trial;
	logic [SLOT_AW-1:0] rem_nxt;

	assign trial = {rem_q, sh_q[KEY_W-1 -: 4]};

	always_comb begin
		rem_nxt = SLOT_AW'(trial);
		for (int q = 1; q < 16; q++) begin
			if (trial >= (SLOT_AW+4)'(q * SLOTS)) begin
				rem_nxt = SLOT_AW'(trial - (SLOT_AW+4)'(q * SLOTS));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dig_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dig_q <= '0;
				if (SLOTS_POW2) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				dig_q <= dig_q + 1'b1;
				if (dig_q == DIG_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= key;
			rem_q <= SLOTS_POW2 ? key[SLOT_AW-1:0] : '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << 4;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule
